FILE: hdl/lbpm_pkg.sv
// ----------------------------------------------------------------------------
// Light bar pair matcher package
// Shared types, constants and a helper function of the pair matcher.
// ----------------------------------------------------------------------------
package lbpm_pkg;

  localparam int unsigned MaxBarsDefault = 32;
  localparam int unsigned CoordW = 16;
  localparam int unsigned AngW = 12;
  localparam int unsigned SumW = 17;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 16;

  localparam logic [AngW-1:0] HalfTurn = 12'd2880;
  localparam logic [AngW-1:0] QuarterTurn = 12'd1440;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_CENTER_Y_GAP = 8'd0,
    REG_MAX_ANGLE_GAP = 8'd1,
    REG_MIN_LENGTH_RATIO = 8'd2,
    REG_MIN_SPAN_RATIO = 8'd3,
    REG_MAX_SPAN_RATIO = 8'd4,
    REG_MIN_GAP_FACTOR = 8'd5,
    REG_MAX_GAP_FACTOR = 8'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] max_center_y_gap;
    logic [10:0] max_angle_gap;
    logic [8:0] min_length_ratio;
    logic [11:0] min_span_ratio;
    logic [11:0] max_span_ratio;
    logic [11:0] min_gap_factor;
    logic [11:0] max_gap_factor;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    max_center_y_gap: 16'd320,
    max_angle_gap: 11'd160,
    min_length_ratio: 9'd179,
    min_span_ratio: 12'd256,
    max_span_ratio: 12'd1280,
    min_gap_factor: 12'd256,
    max_gap_factor: 12'd1280
  };

  typedef struct packed {
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [CoordW-1:0] len;
    logic [AngW-1:0] ang;
    logic [CoordW-1:0] tx;
    logic [CoordW-1:0] ty;
    logic [CoordW-1:0] bx;
    logic [CoordW-1:0] by;
  } bar_entry_t;

  typedef struct packed {
    bar_entry_t bar;
    logic final_bar;
  } bar_req_t;

  typedef struct packed {
    logic found;
    logic [CoordW-1:0] left_top_x;
    logic [CoordW-1:0] left_top_y;
    logic [CoordW-1:0] left_bottom_x;
    logic [CoordW-1:0] left_bottom_y;
    logic [CoordW-1:0] right_top_x;
    logic [CoordW-1:0] right_top_y;
    logic [CoordW-1:0] right_bottom_x;
    logic [CoordW-1:0] right_bottom_y;
    logic [SumW-1:0] armor_center_x;
    logic [SumW-1:0] armor_center_y;
    logic run_end;
  } result_t;

  typedef struct packed {
    logic load;
    logic walk_start;
    logic i_next;
    logic j_first;
    logic j_next;
    logic read;
    logic stage1;
    logic stage2;
    logic take;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic i_done;
    logic j_done;
    logic used_i;
    logic used_j;
    logic pair_ok;
    logic out_free;
    logic pend_valid;
  } dp_status_t;

  function automatic logic [CoordW-1:0] abs_diff(input logic [CoordW-1:0] a,
                                                 input logic [CoordW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

FILE: hdl/lbpm_if.sv
// ----------------------------------------------------------------------------
// Light bar pair matcher channels
// Request channels for bars, armor results and register writes.
// ----------------------------------------------------------------------------
interface lbpm_bar_if;
  logic valid;
  logic ready;
  logic [15:0] bar_center_x;
  logic [15:0] bar_center_y;
  logic [15:0] bar_length;
  logic [11:0] bar_angle;
  logic [15:0] top_x;
  logic [15:0] top_y;
  logic [15:0] bottom_x;
  logic [15:0] bottom_y;
  logic final_bar;
  modport source (output valid, bar_center_x, bar_center_y, bar_length, bar_angle,
                  top_x, top_y, bottom_x, bottom_y, final_bar, input ready);
  modport sink (input valid, bar_center_x, bar_center_y, bar_length, bar_angle,
                top_x, top_y, bottom_x, bottom_y, final_bar, output ready);
endinterface

interface lbpm_armor_if;
  logic valid;
  logic ready;
  logic found;
  logic [15:0] left_top_x;
  logic [15:0] left_top_y;
  logic [15:0] left_bottom_x;
  logic [15:0] left_bottom_y;
  logic [15:0] right_top_x;
  logic [15:0] right_top_y;
  logic [15:0] right_bottom_x;
  logic [15:0] right_bottom_y;
  logic [16:0] armor_center_x;
  logic [16:0] armor_center_y;
  logic run_end;
  modport source (output valid, found, left_top_x, left_top_y, left_bottom_x,
                  left_bottom_y, right_top_x, right_top_y, right_bottom_x,
                  right_bottom_y, armor_center_x, armor_center_y, run_end,
                  input ready);
  modport sink (input valid, found, left_top_x, left_top_y, left_bottom_x,
                left_bottom_y, right_top_x, right_top_y, right_bottom_x,
                right_bottom_y, armor_center_x, armor_center_y, run_end,
                output ready);
endinterface

interface lbpm_cfg_if;
  logic valid;
  logic ready;
  logic [7:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/lbpm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lbpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/lbpm_datapath.sv
// ----------------------------------------------------------------------------
// Light bar pair matcher datapath
// Bar storage, pair index counters, check pipeline and result registers.
// ----------------------------------------------------------------------------
module lbpm_datapath #(
  parameter int unsigned MAX_BARS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lbpm_pkg::cfg_t      cfg_i,
  input  lbpm_pkg::bar_req_t  bar_i,
  input  lbpm_pkg::ctrl_cmd_t cmd_i,
  output lbpm_pkg::dp_status_t status_o,
  output lbpm_pkg::result_t   res_o,
  output logic                res_valid_o,
  input  logic                res_ready_i
);
  import lbpm_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BARS);
  localparam int unsigned CW = $clog2(MAX_BARS + 1);
  localparam int unsigned EW = $bits(bar_entry_t);

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic [MAX_BARS-1:0] used_q, used_d;
  logic we;
  bar_entry_t wr_entry;
  logic [EW-1:0] rdata_a, rdata_b;
  bar_entry_t ent_a, ent_b;

  logic [15:0] ydiff_q;
  logic [11:0] adiff_q;
  logic [15:0] lo_q, hi_q, w_q;
  logic [16:0] s_q;
  logic ok_q;
  logic [11:0] adiff_raw, adiff_fold;

  logic [24:0] len_lhs, len_rhs, w512;
  logic [28:0] span_lo, span_hi, gap_lo, gap_hi;
  logic ok_d;

  result_t pend_q, pend_d, res_q, res_d, new_res;
  logic pend_valid_q, pend_valid_d, res_valid_q, res_valid_d;
  logic out_free;

  always_comb begin
    wr_entry = bar_i.bar;
    if (bar_i.bar.ang >= HalfTurn) begin
      wr_entry.ang = bar_i.bar.ang - HalfTurn;
    end
  end

  assign we = cmd_i.load && (count_q < CW'(MAX_BARS));

  lbpm_ram #(.WIDTH(EW), .DEPTH(MAX_BARS)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.read),
    .raddr_i (i_q[AW-1:0]),
    .rdata_o (rdata_a)
  );

  lbpm_ram #(.WIDTH(EW), .DEPTH(MAX_BARS)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.read),
    .raddr_i (j_q[AW-1:0]),
    .rdata_o (rdata_b)
  );

  assign ent_a = bar_entry_t'(rdata_a);
  assign ent_b = bar_entry_t'(rdata_b);

  assign adiff_raw = (ent_a.ang > ent_b.ang) ? (ent_a.ang - ent_b.ang)
                                             : (ent_b.ang - ent_a.ang);
  assign adiff_fold = (adiff_raw > QuarterTurn) ? (HalfTurn - adiff_raw) : adiff_raw;

  always_ff @(posedge clk_i) begin
    if (cmd_i.stage1) begin
      ydiff_q <= abs_diff(ent_a.cy, ent_b.cy);
      adiff_q <= adiff_fold;
      lo_q <= (ent_a.len < ent_b.len) ? ent_a.len : ent_b.len;
      hi_q <= (ent_a.len < ent_b.len) ? ent_b.len : ent_a.len;
      s_q <= {1'b0, ent_a.len} + {1'b0, ent_b.len};
      w_q <= abs_diff(ent_a.cx, ent_b.cx);
    end
    if (cmd_i.stage2) begin
      ok_q <= ok_d;
    end
  end

  always_comb begin
    len_lhs = {1'b0, lo_q, 8'd0};
    len_rhs = {16'd0, cfg_i.min_length_ratio} * {9'd0, hi_q};
    w512 = {w_q, 9'd0};
    span_lo = {17'd0, cfg_i.min_span_ratio} * {12'd0, s_q};
    span_hi = {17'd0, cfg_i.max_span_ratio} * {12'd0, s_q};
    gap_lo = {17'd0, cfg_i.min_gap_factor} * {12'd0, s_q};
    gap_hi = {17'd0, cfg_i.max_gap_factor} * {12'd0, s_q};
    ok_d = (ydiff_q <= cfg_i.max_center_y_gap) &&
           (adiff_q <= {1'b0, cfg_i.max_angle_gap}) &&
           (len_lhs >= len_rhs) &&
           (s_q != 17'd0) &&
           ({4'd0, w512} >= span_lo) && ({4'd0, w512} <= span_hi) &&
           ({4'd0, w512} >= gap_lo) && ({4'd0, w512} <= gap_hi);
  end

  always_comb begin
    new_res = '0;
    new_res.found = 1'b1;
    new_res.left_top_x = ent_a.tx;
    new_res.left_top_y = ent_a.ty;
    new_res.left_bottom_x = ent_a.bx;
    new_res.left_bottom_y = ent_a.by;
    new_res.right_top_x = ent_b.tx;
    new_res.right_top_y = ent_b.ty;
    new_res.right_bottom_x = ent_b.bx;
    new_res.right_bottom_y = ent_b.by;
    new_res.armor_center_x = {1'b0, ent_a.cx} + {1'b0, ent_b.cx};
    new_res.armor_center_y = {1'b0, ent_a.cy} + {1'b0, ent_b.cy};
  end

  assign out_free = !res_valid_q || res_ready_i;

  always_comb begin
    count_d = count_q;
    i_d = i_q;
    j_d = j_q;
    used_d = used_q;
    pend_d = pend_q;
    pend_valid_d = pend_valid_q;
    res_d = res_q;
    res_valid_d = res_valid_q && !res_ready_i;
    if (we) begin
      count_d = count_q + 1'b1;
    end
    if (cmd_i.walk_start) begin
      i_d = '0;
    end
    if (cmd_i.i_next) begin
      i_d = i_q + 1'b1;
    end
    if (cmd_i.j_first) begin
      j_d = i_q + 1'b1;
    end
    if (cmd_i.j_next) begin
      j_d = j_q + 1'b1;
    end
    if (cmd_i.take) begin
      if (pend_valid_q) begin
        res_d = pend_q;
        res_valid_d = 1'b1;
      end
      pend_d = new_res;
      pend_valid_d = 1'b1;
      used_d[i_q[AW-1:0]] = 1'b1;
      used_d[j_q[AW-1:0]] = 1'b1;
      i_d = i_q + 1'b1;
    end
    if (cmd_i.finish) begin
      res_d = pend_valid_q ? pend_q : '0;
      res_d.run_end = 1'b1;
      res_valid_d = 1'b1;
      pend_valid_d = 1'b0;
      used_d = '0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      i_q <= '0;
      j_q <= '0;
      used_q <= '0;
      pend_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      i_q <= i_d;
      j_q <= j_d;
      used_q <= used_d;
      pend_valid_q <= pend_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    res_q <= res_d;
  end

  assign status_o.i_done = (i_q >= count_q);
  assign status_o.j_done = (j_q >= count_q);
  assign status_o.used_i = used_q[i_q[AW-1:0]];
  assign status_o.used_j = used_q[j_q[AW-1:0]];
  assign status_o.pair_ok = ok_q;
  assign status_o.out_free = out_free;
  assign status_o.pend_valid = pend_valid_q;

  assign res_o = res_q;
  assign res_valid_o = res_valid_q;

endmodule

FILE: hdl/lbpm_ctrl.sv
// ----------------------------------------------------------------------------
// Light bar pair matcher controller
// Sequences bar loading, the greedy pair walk and the frame end.
// ----------------------------------------------------------------------------
module lbpm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 bar_valid_i,
  input  logic                 bar_final_i,
  output logic                 bar_ready_o,
  input  lbpm_pkg::dp_status_t status_i,
  output lbpm_pkg::ctrl_cmd_t  cmd_o
);
  import lbpm_pkg::*;

  typedef enum logic [6:0] {
    ST_LOAD   = 7'b0000001,
    ST_SCAN_I = 7'b0000010,
    ST_SCAN_J = 7'b0000100,
    ST_CALC1  = 7'b0001000,
    ST_CALC2  = 7'b0010000,
    ST_DECIDE = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    bar_ready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        bar_ready_o = 1'b1;
        if (bar_valid_i) begin
          cmd_o.load = 1'b1;
          if (bar_final_i) begin
            cmd_o.walk_start = 1'b1;
            state_d = ST_SCAN_I;
          end
        end
      end
      ST_SCAN_I: begin
        if (status_i.i_done) begin
          state_d = ST_FINISH;
        end else if (status_i.used_i) begin
          cmd_o.i_next = 1'b1;
        end else begin
          cmd_o.j_first = 1'b1;
          state_d = ST_SCAN_J;
        end
      end
      ST_SCAN_J: begin
        if (status_i.j_done) begin
          cmd_o.i_next = 1'b1;
          state_d = ST_SCAN_I;
        end else if (status_i.used_j) begin
          cmd_o.j_next = 1'b1;
        end else begin
          cmd_o.read = 1'b1;
          state_d = ST_CALC1;
        end
      end
      ST_CALC1: begin
        cmd_o.stage1 = 1'b1;
        state_d = ST_CALC2;
      end
      ST_CALC2: begin
        cmd_o.stage2 = 1'b1;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!status_i.pair_ok) begin
          cmd_o.j_next = 1'b1;
          state_d = ST_SCAN_J;
        end else if (!status_i.pend_valid || status_i.out_free) begin
          cmd_o.take = 1'b1;
          state_d = ST_SCAN_I;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/light_bar_pair_matcher_top.sv
// ----------------------------------------------------------------------------
// Light bar pair matcher
// Stores light bars of a frame and reports matched armor bar pairs.
// ----------------------------------------------------------------------------
// Bars are taken one per cycle while loading. After the final bar, the outer
// and inner scans step over used indices; each tested pair passes through a
// RAM read, two check stages and a decision, and the decision waits while a
// pending pair meets a busy output register. Closing the frame waits in the
// finish state until the output register is free.
// Reset loads the default thresholds, empties the bar store and clears flags.
module light_bar_pair_matcher_top #(
  parameter int unsigned MAX_BARS = lbpm_pkg::MaxBarsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  lbpm_bar_if.sink     bar_i,
  lbpm_armor_if.source armor_o,
  lbpm_cfg_if.sink     cfg_i
);
  import lbpm_pkg::*;

  cfg_t cfg_q, cfg_d;
  bar_req_t bar_req;
  ctrl_cmd_t cmd;
  dp_status_t status;
  result_t res;
  logic res_valid;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_MAX_CENTER_Y_GAP: cfg_d.max_center_y_gap = cfg_i.data;
        REG_MAX_ANGLE_GAP:    cfg_d.max_angle_gap = cfg_i.data[10:0];
        REG_MIN_LENGTH_RATIO: cfg_d.min_length_ratio = cfg_i.data[8:0];
        REG_MIN_SPAN_RATIO:   cfg_d.min_span_ratio = cfg_i.data[11:0];
        REG_MAX_SPAN_RATIO:   cfg_d.max_span_ratio = cfg_i.data[11:0];
        REG_MIN_GAP_FACTOR:   cfg_d.min_gap_factor = cfg_i.data[11:0];
        REG_MAX_GAP_FACTOR:   cfg_d.max_gap_factor = cfg_i.data[11:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign bar_req.bar.cx = bar_i.bar_center_x;
  assign bar_req.bar.cy = bar_i.bar_center_y;
  assign bar_req.bar.len = bar_i.bar_length;
  assign bar_req.bar.ang = bar_i.bar_angle;
  assign bar_req.bar.tx = bar_i.top_x;
  assign bar_req.bar.ty = bar_i.top_y;
  assign bar_req.bar.bx = bar_i.bottom_x;
  assign bar_req.bar.by = bar_i.bottom_y;
  assign bar_req.final_bar = bar_i.final_bar;

  lbpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bar_valid_i (bar_i.valid),
    .bar_final_i (bar_i.final_bar),
    .bar_ready_o (bar_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lbpm_datapath #(.MAX_BARS(MAX_BARS)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .bar_i       (bar_req),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (armor_o.ready)
  );

  assign armor_o.valid = res_valid;
  assign armor_o.found = res.found;
  assign armor_o.left_top_x = res.left_top_x;
  assign armor_o.left_top_y = res.left_top_y;
  assign armor_o.left_bottom_x = res.left_bottom_x;
  assign armor_o.left_bottom_y = res.left_bottom_y;
  assign armor_o.right_top_x = res.right_top_x;
  assign armor_o.right_top_y = res.right_top_y;
  assign armor_o.right_bottom_x = res.right_bottom_x;
  assign armor_o.right_bottom_y = res.right_bottom_y;
  assign armor_o.armor_center_x = res.armor_center_x;
  assign armor_o.armor_center_y = res.armor_center_y;
  assign armor_o.run_end = res.run_end;

`ifndef SYNTHESIS
  a_empty_frame_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (armor_o.valid && !armor_o.found) |-> armor_o.run_end)
    else $error("empty result without run end");

  a_no_pending_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bar_i.ready |-> !status.pend_valid)
    else $error("pending pair left while loading bars");

  a_take_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.take && status.pend_valid) |-> status.out_free)
    else $error("pair taken while output register busy");
`endif

endmodule

FILE: verif/light_bar_pair_matcher_top_tb.sv
// ----------------------------------------------------------------------------
// Light bar pair matcher testbench
// Sends frames of light bars, computes the expected armor pairs and compares
// every armor request with them, under random sender gaps and sink stalls.
// ----------------------------------------------------------------------------
module light_bar_pair_matcher_top_tb;
  import lbpm_pkg::*;

  localparam int unsigned NumBars = 32;
  localparam int unsigned IdleLimit = 20000;

  logic clk_i;
  logic rst_ni;

  lbpm_bar_if   bar_if ();
  lbpm_armor_if armor_if ();
  lbpm_cfg_if   cfg_if ();

  light_bar_pair_matcher_top #(.MAX_BARS(NumBars)) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .bar_i   (bar_if.sink),
    .armor_o (armor_if.source),
    .cfg_i   (cfg_if.sink)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  cfg_t       thr;
  bar_entry_t frame_bars[NumBars];
  int         frame_count;
  result_t    armor_queue[$];
  int         fail_count;
  int         idle_cycles;
  int         stall_mode;
  bit         gaps_on;
  int         burst_left;

  function automatic logic [16:0] udiff(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? 17'(a - b) : 17'(b - a);
  endfunction

  function automatic bit pair_accepted(input bar_entry_t a, input bar_entry_t b);
    logic [12:0] dang;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [63:0] span512;
    logic [63:0] len_sum;
    if (udiff(a.cy, b.cy) > thr.max_center_y_gap) return 0;
    dang = (a.ang > b.ang) ? 13'(a.ang - b.ang) : 13'(b.ang - a.ang);
    if (dang > QuarterTurn) dang = HalfTurn - dang;
    if (dang > thr.max_angle_gap) return 0;
    lo = (a.len < b.len) ? a.len : b.len;
    hi = (a.len < b.len) ? b.len : a.len;
    if (64'(lo) * 256 < 64'(thr.min_length_ratio) * hi) return 0;
    len_sum = 64'(a.len) + b.len;
    if (len_sum == 0) return 0;
    span512 = 64'(udiff(a.cx, b.cx)) * 512;
    if (span512 < thr.min_span_ratio * len_sum) return 0;
    if (span512 > thr.max_span_ratio * len_sum) return 0;
    if (span512 < thr.min_gap_factor * len_sum) return 0;
    if (span512 > thr.max_gap_factor * len_sum) return 0;
    return 1;
  endfunction

  task automatic predict_bar(input bar_req_t req);
    bar_entry_t e;
    bit         used[NumBars];
    int         n_pairs;
    result_t    r;
    e = req.bar;
    if (e.ang >= HalfTurn) e.ang = e.ang - HalfTurn;
    if (frame_count < NumBars) begin
      frame_bars[frame_count] = e;
      frame_count++;
    end
    if (!req.final_bar) return;
    n_pairs = 0;
    foreach (used[k]) used[k] = 0;
    for (int i = 0; i < frame_count; i++) begin
      if (used[i]) continue;
      for (int j = i + 1; j < frame_count; j++) begin
        if (used[j]) continue;
        if (pair_accepted(frame_bars[i], frame_bars[j])) begin
          r = '0;
          r.found = 1'b1;
          r.left_top_x = frame_bars[i].tx;
          r.left_top_y = frame_bars[i].ty;
          r.left_bottom_x = frame_bars[i].bx;
          r.left_bottom_y = frame_bars[i].by;
          r.right_top_x = frame_bars[j].tx;
          r.right_top_y = frame_bars[j].ty;
          r.right_bottom_x = frame_bars[j].bx;
          r.right_bottom_y = frame_bars[j].by;
          r.armor_center_x = 17'(frame_bars[i].cx) + frame_bars[j].cx;
          r.armor_center_y = 17'(frame_bars[i].cy) + frame_bars[j].cy;
          armor_queue = {armor_queue, r};
          n_pairs++;
          used[i] = 1;
          used[j] = 1;
          break;
        end
      end
    end
    if (n_pairs == 0) begin
      r = '0;
      armor_queue = {armor_queue, r};
    end
    armor_queue[armor_queue.size()-1].run_end = 1'b1;
    frame_count = 0;
  endtask

  initial begin
    bar_if.valid = 1'b0;
    bar_if.bar_center_x = '0;
    bar_if.bar_center_y = '0;
    bar_if.bar_length = '0;
    bar_if.bar_angle = '0;
    bar_if.top_x = '0;
    bar_if.top_y = '0;
    bar_if.bottom_x = '0;
    bar_if.bottom_y = '0;
    bar_if.final_bar = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    armor_if.ready = 1'b0;
  end

  // Sink stall patterns change by phase so that stalls hit every state.
  always @(negedge clk_i) begin
    case (stall_mode)
      0: armor_if.ready <= 1'b1;
      1: armor_if.ready <= ($urandom_range(0, 3) != 0);
      2: armor_if.ready <= ($urandom_range(0, 3) == 0);
      default: armor_if.ready <= ~armor_if.ready;
    endcase
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (armor_if.valid && armor_if.ready) begin
        got.found = armor_if.found;
        got.left_top_x = armor_if.left_top_x;
        got.left_top_y = armor_if.left_top_y;
        got.left_bottom_x = armor_if.left_bottom_x;
        got.left_bottom_y = armor_if.left_bottom_y;
        got.right_top_x = armor_if.right_top_x;
        got.right_top_y = armor_if.right_top_y;
        got.right_bottom_x = armor_if.right_bottom_x;
        got.right_bottom_y = armor_if.right_bottom_y;
        got.armor_center_x = armor_if.armor_center_x;
        got.armor_center_y = armor_if.armor_center_y;
        got.run_end = armor_if.run_end;
        if (armor_queue.size() == 0) begin
          $display("%0t: unexpected armor request, actual %h", $time, got);
          fail_count++;
        end else begin
          want = armor_queue.pop_front();
          if (got !== want) begin
            $display("%0t: armor mismatch", $time);
            $display("  found      exp %0d act %0d", want.found, got.found);
            $display("  left  top  exp %h/%h act %h/%h", want.left_top_x,
                     want.left_top_y, got.left_top_x, got.left_top_y);
            $display("  left  bot  exp %h/%h act %h/%h", want.left_bottom_x,
                     want.left_bottom_y, got.left_bottom_x, got.left_bottom_y);
            $display("  right top  exp %h/%h act %h/%h", want.right_top_x,
                     want.right_top_y, got.right_top_x, got.right_top_y);
            $display("  right bot  exp %h/%h act %h/%h", want.right_bottom_x,
                     want.right_bottom_y, got.right_bottom_x, got.right_bottom_y);
            $display("  center     exp %h/%h act %h/%h", want.armor_center_x,
                     want.armor_center_y, got.armor_center_x, got.armor_center_y);
            $display("  run_end    exp %0d act %0d", want.run_end, got.run_end);
            fail_count++;
          end
        end
      end
      if ((bar_if.valid && bar_if.ready) || (armor_if.valid && armor_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("light_bar_pair_matcher_top regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // The request stays valid after acceptance so that the next one can follow
  // at once; a gap or a drain takes it down.
  task automatic send_bar(input bar_req_t req);
    if (gaps_on) begin
      if (burst_left == 0) begin
        bar_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    bar_if.valid <= 1'b1;
    bar_if.bar_center_x <= req.bar.cx;
    bar_if.bar_center_y <= req.bar.cy;
    bar_if.bar_length <= req.bar.len;
    bar_if.bar_angle <= req.bar.ang;
    bar_if.top_x <= req.bar.tx;
    bar_if.top_y <= req.bar.ty;
    bar_if.bottom_x <= req.bar.bx;
    bar_if.bottom_y <= req.bar.by;
    bar_if.final_bar <= req.final_bar;
    do @(posedge clk_i); while (!bar_if.ready);
    predict_bar(req);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    bar_if.valid <= 1'b0;
    while (armor_queue.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_MAX_CENTER_Y_GAP: thr.max_center_y_gap = value;
      REG_MAX_ANGLE_GAP: thr.max_angle_gap = value[10:0];
      REG_MIN_LENGTH_RATIO: thr.min_length_ratio = value[8:0];
      REG_MIN_SPAN_RATIO: thr.min_span_ratio = value[11:0];
      REG_MAX_SPAN_RATIO: thr.max_span_ratio = value[11:0];
      REG_MIN_GAP_FACTOR: thr.min_gap_factor = value[11:0];
      REG_MAX_GAP_FACTOR: thr.max_gap_factor = value[11:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_thresholds(input cfg_t c);
    write_reg(REG_MAX_CENTER_Y_GAP, c.max_center_y_gap);
    write_reg(REG_MAX_ANGLE_GAP, 16'(c.max_angle_gap));
    write_reg(REG_MIN_LENGTH_RATIO, 16'(c.min_length_ratio));
    write_reg(REG_MIN_SPAN_RATIO, 16'(c.min_span_ratio));
    write_reg(REG_MAX_SPAN_RATIO, 16'(c.max_span_ratio));
    write_reg(REG_MIN_GAP_FACTOR, 16'(c.min_gap_factor));
    write_reg(REG_MAX_GAP_FACTOR, 16'(c.max_gap_factor));
  endtask

  function automatic bar_req_t make_bar(input logic [15:0] cx, input logic [15:0] cy,
                                        input logic [15:0] len, input logic [11:0] ang,
                                        input bit last);
    bar_req_t r;
    r.bar.cx = cx;
    r.bar.cy = cy;
    r.bar.len = len;
    r.bar.ang = ang;
    r.bar.tx = 16'($urandom);
    r.bar.ty = 16'($urandom);
    r.bar.bx = 16'($urandom);
    r.bar.by = 16'($urandom);
    r.final_bar = last;
    return r;
  endfunction

  // Mostly plausible bars near a shared row, with a spread of lengths.
  function automatic bar_req_t plausible_bar(input logic [15:0] cx, input bit last);
    bar_req_t r;
    logic [15:0] len;
    len = 16'($urandom_range(200, 900));
    if ($urandom_range(0, 15) == 0) len = 16'($urandom);
    r = make_bar(cx, 16'($urandom_range(3000, 3400)), len,
                 12'(($urandom_range(0, 1) ? $urandom_range(0, 200)
                                           : $urandom_range(2700, 4095))), last);
    return r;
  endfunction

  task automatic send_frame(input int n_bars);
    int x;
    x = $urandom_range(0, 2000);
    for (int k = 0; k < n_bars; k++) begin
      send_bar(plausible_bar(16'(x), k == n_bars - 1));
      x = x + $urandom_range(100, 1800);
      if (x > 65535) x = 65535;
    end
  endtask

  task automatic test_directed();
    send_bar(make_bar(16'd1000, 16'd3000, 16'd500, 12'd80, 1'b0));
    send_bar(make_bar(16'd1500, 16'd3100, 16'd520, 12'd2870, 1'b1));
    send_bar(make_bar(16'd0, 16'd0, 16'd0, 12'd0, 1'b1));
    send_bar(make_bar(16'd0, 16'd0, 16'd0, 12'd0, 1'b0));
    send_bar(make_bar(16'd65535, 16'd65535, 16'd65535, 12'd4095, 1'b1));
    send_bar(make_bar(16'd65535, 16'd65535, 16'd65535, 12'd2879, 1'b0));
    send_bar(make_bar(16'd65535, 16'd65535, 16'd65535, 12'd1440, 1'b1));
    send_bar(make_bar(16'd1000, 16'd3000, 16'd500, 12'd0, 1'b0));
    send_bar(make_bar(16'd1300, 16'd3000, 16'd500, 12'd2000, 1'b0));
    send_bar(make_bar(16'd1500, 16'd3320, 16'd500, 12'd2880, 1'b0));
    send_bar(make_bar(16'd2000, 16'd3000, 16'd360, 12'd100, 1'b1));
    drain_results();
    write_reg(REG_MIN_LENGTH_RATIO, 16'd0);
    send_bar(make_bar(16'd1000, 16'd3000, 16'd0, 12'd0, 1'b0));
    send_bar(make_bar(16'd1100, 16'd3000, 16'd100, 12'd0, 1'b0));
    send_bar(make_bar(16'd1200, 16'd3000, 16'd0, 12'd0, 1'b0));
    send_bar(make_bar(16'd1300, 16'd3000, 16'd0, 12'd0, 1'b1));
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= 8'd200;
    cfg_if.data <= 16'hFFFF;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
    load_thresholds(CfgReset);
  endtask

  task automatic test_overflow();
    for (int k = 0; k < NumBars + 3; k++) begin
      send_bar(make_bar(16'(k * 800), 16'd3000, 16'd600, 12'd0, k == NumBars + 2));
    end
    for (int k = 0; k < NumBars; k++) begin
      send_bar(make_bar(16'(k * 800 + 400), 16'd3000, 16'd600, 12'd0, k == NumBars - 1));
    end
    drain_results();
  endtask

  task automatic test_random_frames(input int n_items);
    int sent;
    int n;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
          send_bar(make_bar(16'($urandom), 16'($urandom), 16'($urandom),
                            12'($urandom), k == n - 1));
        end
      end else begin
        n = $urandom_range(1, 10);
        send_frame(n);
      end
      sent += n;
      if ($urandom_range(0, 15) == 0) drain_results();
    end
    drain_results();
  endtask

  task automatic test_threshold_sweep();
    cfg_t c;
    c = '{16'd65535, 11'd1440, 9'd0, 12'd0, 12'd4095, 12'd0, 12'd4095};
    load_thresholds(c);
    test_random_frames(40);
    c = '{16'd0, 11'd0, 9'd256, 12'd4095, 12'd0, 12'd4095, 12'd0};
    load_thresholds(c);
    test_random_frames(20);
    for (int k = 0; k < 3; k++) begin
      c.max_center_y_gap = 16'($urandom_range(0, 600));
      c.max_angle_gap = 11'($urandom_range(0, 1440));
      c.min_length_ratio = 9'($urandom_range(0, 256));
      c.min_span_ratio = 12'($urandom_range(0, 800));
      c.max_span_ratio = 12'($urandom_range(800, 4095));
      c.min_gap_factor = 12'($urandom_range(0, 800));
      c.max_gap_factor = 12'($urandom_range(800, 4095));
      load_thresholds(c);
      test_random_frames(30);
    end
    load_thresholds(CfgReset);
  endtask

  initial begin
    thr = CfgReset;
    frame_count = 0;
    fail_count = 0;
    idle_cycles = 0;
    stall_mode = 0;
    gaps_on = 1'b0;
    burst_left = 0;
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    stall_mode = 3;
    gaps_on = 1'b1;
    test_overflow();
    stall_mode = 1;
    test_random_frames(100);
    stall_mode = 2;
    test_threshold_sweep();
    stall_mode = 0;
    gaps_on = 1'b0;
    test_random_frames(20);
    drain_results();
    repeat (50) @(negedge clk_i);
    if (fail_count == 0 && armor_queue.size() == 0) begin
      $display("light_bar_pair_matcher_top regression: pass");
    end else begin
      $display("light_bar_pair_matcher_top regression: fail");
    end
    $finish;
  end

endmodule

FILE: light_bar_pair_matcher_top.f
hdl/lbpm_pkg.sv
hdl/lbpm_if.sv
hdl/lbpm_ram.sv
hdl/lbpm_datapath.sv
hdl/lbpm_ctrl.sv
hdl/light_bar_pair_matcher_top.sv
verif/light_bar_pair_matcher_top_tb.sv
